/* rtl/core/k35lpf_pkg.sv */
package k35lpf_pkg;

  localparam int DEF_CHANNELS = 2;
  localparam int TANH_N       = 129;
  localparam int SAMPLE_W     = 24;
  localparam int CFG_ADDR_W   = 3;
  localparam int CFG_DATA_W   = 32;

  // register indexes of the write port
  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_G_COEF      = 3'd0,
    CFG_K_COEF      = 3'd1,
    CFG_SAT_GAIN    = 3'd2,
    CFG_LPF_FB_GAIN = 3'd3,
    CFG_HPF_FB_GAIN = 3'd4,
    CFG_NORM_GAIN   = 3'd5,
    CFG_INV_K       = 3'd6
  } cfg_idx_t;

  // datapath step issued by the controller
  typedef enum logic [4:0] {
    ST_NONE,
    ST_LOAD,
    ST_LP1_MUL,
    ST_LP1_UPD,
    ST_FBH,
    ST_FBL,
    ST_NORM_MUL,
    ST_NORM_RES,
    ST_TANH_IDX,
    ST_TANH_MUL,
    ST_TANH_RES,
    ST_LP2_MUL,
    ST_LP2_UPD,
    ST_K_MUL,
    ST_K_RES,
    ST_HP_MUL,
    ST_HP_UPD,
    ST_OUT,
    ST_ZERO
  } step_t;

  typedef struct packed {
    step_t step;
  } dp_cmd_t;

  typedef struct packed {
    logic chan_ok;
  } dp_status_t;

  // tanh(i/16) as unsigned Q0.28, built from a rounded exp(-1/8) recurrence
  typedef logic [27:0] tanh_tab_t [0:TANH_N-1];

  // shift and subtract quotient, only used while building the table
  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[63:0], n[b]};
      if (r >= {1'b0, d}) begin
        r    = r - {1'b0, d};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic tanh_tab_t build_tanh_tab();
    tanh_tab_t   tab;
    logic [63:0] p;
    logic [63:0] den;
    logic [63:0] num;
    p = 64'd1 << 32;
    for (int i = 0; i < TANH_N; i++) begin
      den    = (64'd1 << 32) + p;
      num    = ((64'd1 << 32) - p) << 28;
      tab[i] = 28'(udiv64(num + (den >> 1), den));
      p      = (p * 64'd3790295335 + (64'd1 << 31)) >> 32;
    end
    return tab;
  endfunction

  localparam tanh_tab_t TANH_TAB = build_tanh_tab();

endpackage

/* rtl/core/k35lpf_ctrl.sv */
module k35lpf_ctrl
  import k35lpf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  typedef enum logic [17:0] {
    S_IDLE     = 18'b000000000000000001,
    S_LP1_MUL  = 18'b000000000000000010,
    S_LP1_UPD  = 18'b000000000000000100,
    S_FBH      = 18'b000000000000001000,
    S_FBL      = 18'b000000000000010000,
    S_NORM_MUL = 18'b000000000000100000,
    S_NORM_RES = 18'b000000000001000000,
    S_TANH_IDX = 18'b000000000010000000,
    S_TANH_MUL = 18'b000000000100000000,
    S_TANH_RES = 18'b000000001000000000,
    S_LP2_MUL  = 18'b000000010000000000,
    S_LP2_UPD  = 18'b000000100000000000,
    S_K_MUL    = 18'b000001000000000000,
    S_K_RES    = 18'b000010000000000000,
    S_HP_MUL   = 18'b000100000000000000,
    S_HP_UPD   = 18'b001000000000000000,
    S_OUT      = 18'b010000000000000000,
    S_ZERO     = 18'b100000000000000000
  } state_t;

  state_t state, state_next;
  logic   out_free;
  logic   accept;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // sequence and step select
  always_comb begin
    state_next = state;
    cmd.step   = ST_NONE;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          cmd.step   = ST_LOAD;
          state_next = status.chan_ok ? S_LP1_MUL : S_ZERO;
        end
      end
      S_LP1_MUL:  begin cmd.step = ST_LP1_MUL;  state_next = S_LP1_UPD;  end
      S_LP1_UPD:  begin cmd.step = ST_LP1_UPD;  state_next = S_FBH;      end
      S_FBH:      begin cmd.step = ST_FBH;      state_next = S_FBL;      end
      S_FBL:      begin cmd.step = ST_FBL;      state_next = S_NORM_MUL; end
      S_NORM_MUL: begin cmd.step = ST_NORM_MUL; state_next = S_NORM_RES; end
      S_NORM_RES: begin cmd.step = ST_NORM_RES; state_next = S_TANH_IDX; end
      S_TANH_IDX: begin cmd.step = ST_TANH_IDX; state_next = S_TANH_MUL; end
      S_TANH_MUL: begin cmd.step = ST_TANH_MUL; state_next = S_TANH_RES; end
      S_TANH_RES: begin cmd.step = ST_TANH_RES; state_next = S_LP2_MUL;  end
      S_LP2_MUL:  begin cmd.step = ST_LP2_MUL;  state_next = S_LP2_UPD;  end
      S_LP2_UPD:  begin cmd.step = ST_LP2_UPD;  state_next = S_K_MUL;    end
      S_K_MUL:    begin cmd.step = ST_K_MUL;    state_next = S_K_RES;    end
      S_K_RES:    begin cmd.step = ST_K_RES;    state_next = S_HP_MUL;   end
      S_HP_MUL:   begin cmd.step = ST_HP_MUL;   state_next = S_HP_UPD;   end
      S_HP_UPD:   begin cmd.step = ST_HP_UPD;   state_next = S_OUT;      end
      S_OUT: begin
        if (out_free) begin
          cmd.step   = ST_OUT;
          state_next = S_IDLE;
        end
      end
      S_ZERO: begin
        if (out_free) begin
          cmd.step   = ST_ZERO;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.step == ST_OUT || cmd.step == ST_ZERO) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

/* rtl/core/k35lpf_datapath.sv */
module k35lpf_datapath
  import k35lpf_pkg::*;
#(
  parameter int CHANNELS = DEF_CHANNELS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic signed [SAMPLE_W-1:0]  sample_in,
  input  logic                        chan,
  input  logic                        cfg_we,
  input  logic [CFG_ADDR_W-1:0]       cfg_addr,
  input  logic [CFG_DATA_W-1:0]       cfg_data,
  input  dp_cmd_t                     cmd,
  output dp_status_t                  status,
  output logic signed [SAMPLE_W-1:0]  sample_out
);

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // configuration registers
  logic        [27:0] g_coef;
  logic        [29:0] k_coef;
  logic        [30:0] sat_gain;
  logic signed [31:0] lpf_fb_gain;
  logic signed [28:0] hpf_fb_gain;
  logic        [30:0] norm_gain;
  logic        [30:0] inv_k;

  // per-channel states
  logic signed [31:0] s1 [CHANNELS];
  logic signed [31:0] s2 [CHANNELS];
  logic signed [31:0] hp [CHANNELS];

  // working registers
  logic [CH_W-1:0]    ch_idx;
  logic signed [31:0] x_reg, y1, t1, acc, w, b2, y;
  logic signed [31:0] ti, td;
  logic [23:0]        frac;
  logic               neg, big;
  logic signed [63:0] prod;
  logic               sh24;

  // multiplier operands
  logic signed [31:0] mul_a, mul_b;
  logic               mul_en, mul_sh24;

  logic signed [63:0] rnd_sum;
  logic signed [63:0] rnd_val;
  logic signed [31:0] rsat;
  logic signed [31:0] s1_c, s2_c, hp_c;
  logic signed [31:0] pole_b, pole_s;
  logic signed [31:0] pole_base;
  logic signed [31:0] fb;
  logic [31:0]        v_abs;
  logic [6:0]         tidx;
  logic signed [31:0] tval;
  logic signed [32:0] o_sum;
  logic signed [27:0] o_val;

  function automatic logic signed [31:0] sat64(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] sadd(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    logic signed [32:0] s;
    s = {a[31], a} + {b[31], b};
    if (s[32] != s[31]) return s[32] ? 32'sh80000000 : 32'sh7fffffff;
    return s[31:0];
  endfunction

  function automatic logic signed [31:0] ssub(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    logic signed [32:0] s;
    s = {a[31], a} - {b[31], b};
    if (s[32] != s[31]) return s[32] ? 32'sh80000000 : 32'sh7fffffff;
    return s[31:0];
  endfunction

  assign status.chan_ok = ({31'd0, chan} < CHANNELS);

  assign s1_c = s1[ch_idx];
  assign s2_c = s2[ch_idx];
  assign hp_c = hp[ch_idx];

  // rounding and saturation of the last product
  assign rnd_sum = prod + (sh24 ? (64'sd1 <<< 23) : (64'sd1 <<< 27));
  assign rnd_val = sh24 ? (rnd_sum >>> 24) : (rnd_sum >>> 28);
  assign rsat    = sat64(rnd_val);

  // one-pole update on the state selected by the step
  always_comb begin
    unique case (cmd.step)
      ST_LP2_UPD: pole_base = s2_c;
      ST_HP_UPD:  pole_base = hp_c;
      default:    pole_base = s1_c;
    endcase
  end
  assign pole_b = sadd(rsat, pole_base);
  assign pole_s = sadd(rsat, pole_b);
  assign fb     = sadd(t1, rsat);

  // tanh table lookup
  assign v_abs = rsat[31] ? (32'd0 - 32'(rsat)) : 32'(rsat);
  assign tidx  = v_abs[30:24];
  assign tval  = ti + rsat;

  // output rounding to Q1.23
  assign o_sum = {rsat[31], rsat} + 33'sd16;
  assign o_val = o_sum[32:5];

  // operand select
  always_comb begin
    mul_a    = '0;
    mul_b    = '0;
    mul_en   = 1'b0;
    mul_sh24 = 1'b0;
    unique case (cmd.step)
      ST_LP1_MUL: begin
        mul_a = ssub(x_reg, s1_c); mul_b = {4'd0, g_coef}; mul_en = 1'b1;
      end
      ST_LP1_UPD: begin
        mul_a = hp_c; mul_b = {{3{hpf_fb_gain[28]}}, hpf_fb_gain}; mul_en = 1'b1;
      end
      ST_FBH: begin
        mul_a = s2_c; mul_b = lpf_fb_gain; mul_en = 1'b1;
      end
      ST_NORM_MUL: begin
        mul_a = acc; mul_b = {1'b0, norm_gain}; mul_en = 1'b1;
      end
      ST_NORM_RES: begin
        mul_a = rsat; mul_b = {1'b0, sat_gain}; mul_en = 1'b1;
      end
      ST_TANH_MUL: begin
        mul_a = td; mul_b = {8'd0, frac}; mul_en = 1'b1; mul_sh24 = 1'b1;
      end
      ST_LP2_MUL: begin
        mul_a = ssub(w, s2_c); mul_b = {4'd0, g_coef}; mul_en = 1'b1;
      end
      ST_K_MUL: begin
        mul_a = {2'd0, k_coef}; mul_b = b2; mul_en = 1'b1;
      end
      ST_HP_MUL: begin
        mul_a = ssub(y, hp_c); mul_b = {4'd0, g_coef}; mul_en = 1'b1;
      end
      ST_HP_UPD: begin
        mul_a = y; mul_b = {1'b0, inv_k}; mul_en = 1'b1;
      end
      default: ;
    endcase
  end

  // shared multiplier
  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod <= mul_a * mul_b;
      sh24 <= mul_sh24;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      g_coef      <= '0;
      k_coef      <= '0;
      sat_gain    <= 31'h1000_0000;
      lpf_fb_gain <= '0;
      hpf_fb_gain <= '0;
      norm_gain   <= 31'h1000_0000;
      inv_k       <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_G_COEF:      g_coef      <= cfg_data[27:0];
        CFG_K_COEF:      k_coef      <= cfg_data[29:0];
        CFG_SAT_GAIN:    sat_gain    <= cfg_data[30:0];
        CFG_LPF_FB_GAIN: lpf_fb_gain <= cfg_data;
        CFG_HPF_FB_GAIN: hpf_fb_gain <= cfg_data[28:0];
        CFG_NORM_GAIN:   norm_gain   <= cfg_data[30:0];
        CFG_INV_K:       inv_k       <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  // filter states
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        s1[i] <= '0;
        s2[i] <= '0;
        hp[i] <= '0;
      end
    end else begin
      unique case (cmd.step)
        ST_LP1_UPD: s1[ch_idx] <= pole_s;
        ST_LP2_UPD: s2[ch_idx] <= pole_s;
        ST_HP_UPD:  hp[ch_idx] <= pole_s;
        default: ;
      endcase
    end
  end

  // working values
  always_ff @(posedge clk) begin
    unique case (cmd.step)
      ST_LOAD: begin
        x_reg  <= {{3{sample_in[SAMPLE_W-1]}}, sample_in, 5'd0};
        ch_idx <= CH_W'(chan);
      end
      ST_LP1_UPD: y1  <= pole_b;
      ST_FBH:     t1  <= rsat;
      ST_FBL:     acc <= sadd(y1, fb);
      ST_TANH_IDX: begin
        neg  <= rsat[31];
        big  <= v_abs[31];
        frac <= v_abs[23:0];
        ti   <= {4'd0, TANH_TAB[{1'b0, tidx}]};
        td   <= {4'd0, TANH_TAB[{1'b0, tidx} + 8'd1]} - {4'd0, TANH_TAB[{1'b0, tidx}]};
      end
      ST_TANH_RES: begin
        if (big) begin
          w <= neg ? -{4'd0, TANH_TAB[TANH_N-1]} : {4'd0, TANH_TAB[TANH_N-1]};
        end else begin
          w <= neg ? -tval : tval;
        end
      end
      ST_LP2_UPD: b2 <= pole_b;
      ST_K_RES:   y  <= rsat;
      ST_OUT: begin
        if (k_coef == '0) begin
          sample_out <= '0;
        end else if (o_val > 28'sd8388607) begin
          sample_out <= 24'sh7fffff;
        end else if (o_val < -28'sd8388608) begin
          sample_out <= 24'sh800000;
        end else begin
          sample_out <= o_val[23:0];
        end
      end
      ST_ZERO: sample_out <= '0;
      default: ;
    endcase
  end

endmodule

/* rtl/core/korg35_lowpass_filter.sv */
// Nonlinear 35-style lowpass for interleaved audio channels.
// Input transfer: s_axis_tdata carries a Q1.23 sample, s_axis_tuser the
// channel whose filter state it uses. Output transfer: m_axis_tdata carries
// the filtered Q1.23 sample, saturated.
// Coefficients are written through cfg_we/cfg_addr/cfg_data; the user must
// write them only while idle, as the block itself does not enforce this.
// One sample is worked on at a time, stepping through a single shared
// 32x32 multiplier: the result is registered in the output step, which
// follows the filter steps, and the next sample is taken after it. A
// sample on a channel beyond CHANNELS gives zero and touches no state.
// If the receiver stalls, the finished result is held in the output
// register; the next sample is still taken and computed, and waits before
// its final step until the output register is free.
// Synchronous reset clears all filter states and loads the register
// defaults (unity drive and normalizing gain, everything else zero).
module korg35_lowpass_filter
  import k35lpf_pkg::*;
#(
  parameter int CHANNELS = DEF_CHANNELS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [23:0]            s_axis_tdata,   // sample_in[23:0]
  input  logic [0:0]             s_axis_tuser,   // chan[0]
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [23:0]            m_axis_tdata,   // sample_out[23:0]
  input  logic                   cfg_we,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  dp_cmd_t                    cmd;
  dp_status_t                 status;
  logic signed [SAMPLE_W-1:0] sample_out;

  // sequencer
  k35lpf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .status    (status),
    .cmd       (cmd)
  );

  // arithmetic, states and coefficients
  k35lpf_datapath #(
    .CHANNELS (CHANNELS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .sample_in  (s_axis_tdata),
    .chan       (s_axis_tuser[0]),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .status     (status),
    .sample_out (sample_out)
  );

  assign m_axis_tdata = sample_out;

endmodule
